/* src/tepg_pkg.sv */
package tepg_pkg;

    // Fixed field widths
    localparam int PORT_COORD_W = 11;
    localparam int MAX_COORD_W  = 12;
    localparam int SCALE_W      = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int OUT_W        = 8;
    localparam int NUM_W        = 2 * SCALE_W;
    localparam int ROOT_W       = SCALE_W;
    localparam int RAY_W        = 51;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_DEPTH_SCALE = 2'd2
    } cfg_reg_t;

    // Q62 product, truncated
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[125:62];
    endfunction

    // Truncated quotient by long division, evaluated only while building the ray table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine or cosine of ray k (k * pi / 2^(tb-1)) in Q50, from truncated Taylor series
    function automatic logic [RAY_W-1:0] ray_val(input int tb, input int k, input bit want_cos);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] dv;
        x  = (PI_Q62 >> (tb - 1)) * 64'(k);
        x2 = mul_q62(x, x);
        term = x;
        s = x;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                dv = 64'((2 * n) * (2 * n + 1));
                term = udiv64(mul_q62(term, x2), dv);
                s = n[0] ? s - term : s + term;
            end
        end
        term = ONE_Q62;
        c = ONE_Q62;
        for (int n = 1; n < 40; n++) begin
            if (term != 64'd0) begin
                dv = 64'((2 * n - 1) * (2 * n));
                term = udiv64(mul_q62(term, x2), dv);
                c = n[0] ? c - term : c + term;
            end
        end
        return want_cos ? c[62:12] : s[62:12];
    endfunction

endpackage

/* src/tunnel_effect_pixel_gen_unit.sv */
// Throughput: one pixel per cycle; a single stall enable freezes every stage at once.
// Depth runs through a 32-stage restoring divider (scale^2 / distance^2) and a
// 16-stage restoring square root, one bit per stage; the angle ray search sits
// alongside the first divider stages, one binary-search step per stage.
// Reset (aresetn low, synchronous) clears all valid bits and reloads the center and scale.
module tunnel_effect_pixel_gen_unit import tepg_pkg::*; #(
    parameter int COORD_BITS = 11,
    parameter int TEX_BITS   = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PORT_COORD_W-1:0] s_pixel_x,
    input  logic [PORT_COORD_W-1:0] s_pixel_y,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_W-1:0]        m_depth_byte,
    output logic [OUT_W-1:0]        m_angle_byte,
    output logic [OUT_W-1:0]        m_texel,
    output logic                    m_at_center
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = 2 * CW + 1;
    localparam int LOG   = TEX_BITS - 3;
    localparam int OCT   = 2 ** LOG;
    localparam int SR_W  = ROOT_W + 1;
    localparam int RS_W  = ROOT_W + 3;
    localparam int NSTG  = 1 + NUM_W + ROOT_W;
    localparam logic [9:0] HALF_K   = 10'(2 ** (TEX_BITS - 1));
    localparam logic [9:0] QUART_K  = 10'(2 ** (TEX_BITS - 2));
    localparam logic [OUT_W-1:0] TEX_MASK = OUT_W'(2 ** TEX_BITS - 1);

    typedef struct packed {
        logic                 v;
        logic signed [CW:0]   dx;
        logic signed [CW:0]   dy;
        logic [SCALE_W-1:0]   scale;
    } front_t;

    typedef struct packed {
        logic              v;
        logic              ctr;
        logic              negx;
        logic              negy;
        logic              swp;
        logic              eqab;
        logic              axz;
        logic              ayz;
        logic [CW-1:0]     a;
        logic [CW-1:0]     b;
        logic [LOG-1:0]    kk;
        logic [DW-1:0]     dd;
        logic [DW-1:0]     rd;
        logic [NUM_W-1:0]  nq;
        logic [SR_W-1:0]   sr;
        logic [ROOT_W-1:0] root;
    } pipe_t;

    logic [PORT_COORD_W-1:0] center_x_reg;
    logic [PORT_COORD_W-1:0] center_y_reg;
    logic [SCALE_W-1:0]      depth_scale_reg;

    front_t front_reg;
    front_t front_next;
    pipe_t  stage_reg  [NSTG];
    pipe_t  stage_next [NSTG];

    logic                m_valid_reg;
    logic [OUT_W-1:0]    depth_reg;
    logic [OUT_W-1:0]    angle_reg;
    logic [OUT_W-1:0]    texel_reg;
    logic                center_reg;
    logic                en;

    logic [RAY_W-1:0] sin_tab [OCT];
    logic [RAY_W-1:0] cos_tab [OCT];

    // Ray boundary table, built at elaboration
    for (genvar g = 0; g < OCT; g++) begin : g_tab
        localparam logic [RAY_W-1:0] SIN_V = ray_val(TEX_BITS, g, 1'b0);
        localparam logic [RAY_W-1:0] COS_V = ray_val(TEX_BITS, g, 1'b1);
        assign sin_tab[g] = SIN_V;
        assign cos_tab[g] = COS_V;
    end

    // Advance the whole pipe unless the output holds an untaken result
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= PORT_COORD_W'(320);
            center_y_reg    <= PORT_COORD_W'(180);
            depth_scale_reg <= SCALE_W'(4608);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CENTER_X:    center_x_reg    <= cfg_wr_data[PORT_COORD_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wr_data[PORT_COORD_W-1:0];
                REG_DEPTH_SCALE: depth_scale_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Front stage: offsets from the center
    logic [MAX_COORD_W-1:0] px_ext, py_ext, cx_ext, cy_ext;
    assign px_ext = {1'b0, s_pixel_x};
    assign py_ext = {1'b0, s_pixel_y};
    assign cx_ext = {1'b0, center_x_reg};
    assign cy_ext = {1'b0, center_y_reg};

    always_comb begin
        front_next.v     = s_valid;
        front_next.dx    = $signed({1'b0, px_ext[CW-1:0]}) - $signed({1'b0, cx_ext[CW-1:0]});
        front_next.dy    = $signed({1'b0, py_ext[CW-1:0]}) - $signed({1'b0, cy_ext[CW-1:0]});
        front_next.scale = depth_scale_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.v <= 1'b0;
        end else if (en) begin
            front_reg <= front_next;
        end
    end

    // Squares and octant folding
    logic [CW-1:0]   ax, ay;
    logic [2*CW-1:0] axsq, aysq;
    logic [NUM_W-1:0] s2;
    assign ax   = front_reg.dx[CW] ? CW'(-front_reg.dx) : CW'(front_reg.dx);
    assign ay   = front_reg.dy[CW] ? CW'(-front_reg.dy) : CW'(front_reg.dy);
    assign axsq = ax * ax;
    assign aysq = ay * ay;
    assign s2   = front_reg.scale * front_reg.scale;

    always_comb begin
        stage_next[0].v    = front_reg.v;
        stage_next[0].dd   = {1'b0, axsq} + {1'b0, aysq};
        stage_next[0].ctr  = (ax == '0) && (ay == '0);
        stage_next[0].negx = front_reg.dx[CW];
        stage_next[0].negy = front_reg.dy[CW];
        stage_next[0].swp  = ay > ax;
        stage_next[0].eqab = ay == ax;
        stage_next[0].axz  = ax == '0;
        stage_next[0].ayz  = ay == '0;
        stage_next[0].a    = (ay > ax) ? ay : ax;
        stage_next[0].b    = (ay > ax) ? ax : ay;
        stage_next[0].kk   = '0;
        stage_next[0].rd   = '0;
        stage_next[0].nq   = s2;
        stage_next[0].sr   = '0;
        stage_next[0].root = '0;
    end

    // Divider stages, one quotient bit each; ray search in the first few
    for (genvar i = 0; i < NUM_W; i++) begin : g_div
        logic [DW:0]    rsh;
        logic           ge;
        logic [LOG-1:0] kk_new;

        if (i < LOG) begin : g_ray
            logic [LOG-1:0]      t;
            logic [CW+RAY_W-1:0] lhs, rhs;
            assign t      = stage_reg[i].kk | LOG'(1 << (LOG - 1 - i));
            assign lhs    = stage_reg[i].b * cos_tab[t];
            assign rhs    = stage_reg[i].a * sin_tab[t];
            assign kk_new = (lhs >= rhs) ? t : stage_reg[i].kk;
        end else begin : g_hold
            assign kk_new = stage_reg[i].kk;
        end

        assign rsh = {stage_reg[i].rd, stage_reg[i].nq[NUM_W-1]};
        assign ge  = rsh >= {1'b0, stage_reg[i].dd};

        always_comb begin
            stage_next[i+1]    = stage_reg[i];
            stage_next[i+1].kk = kk_new;
            stage_next[i+1].rd = ge ? DW'(rsh - {1'b0, stage_reg[i].dd}) : DW'(rsh);
            stage_next[i+1].nq = {stage_reg[i].nq[NUM_W-2:0], ge};
        end
    end

    // Square root stages, one root bit each
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int IX = NUM_W + j;
        logic [RS_W-1:0] rs, trial;
        logic            ge;

        assign rs    = {stage_reg[IX].sr, stage_reg[IX].nq[NUM_W-1 -: 2]};
        assign trial = {1'b0, stage_reg[IX].root, 2'b01};
        assign ge    = rs >= trial;

        always_comb begin
            stage_next[IX+1]      = stage_reg[IX];
            stage_next[IX+1].sr   = ge ? SR_W'(rs - trial) : SR_W'(rs);
            stage_next[IX+1].root = {stage_reg[IX].root[ROOT_W-2:0], ge};
            stage_next[IX+1].nq   = {stage_reg[IX].nq[NUM_W-3:0], 2'b00};
        end
    end

    // Stage registers
    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[k].v <= 1'b0;
            end else if (en) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Angle from ray count and octant
    pipe_t      last;
    logic [9:0] cnt, u, kv;
    logic       exact;
    logic [OUT_W-1:0] depth_v, angle_v;
    assign last = stage_reg[NSTG-1];

    always_comb begin
        cnt   = 10'(last.kk);
        exact = last.swp ? last.axz : (last.ayz || last.eqab);
        u     = last.swp ? QUART_K - cnt - {9'd0, !last.axz} : cnt + {9'd0, last.eqab};
        kv    = last.negx ? HALF_K - u - {9'd0, !exact} : u;
        if (last.negy) begin
            kv = 10'd0 - kv;
        end
        depth_v = OUT_W'(last.root[TEX_BITS-1:0]);
        angle_v = kv[OUT_W-1:0];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= last.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (last.ctr) begin
                depth_reg  <= '0;
                angle_reg  <= '0;
                texel_reg  <= '0;
                center_reg <= 1'b1;
            end else begin
                depth_reg  <= depth_v;
                angle_reg  <= angle_v;
                texel_reg  <= depth_v ^ (angle_v & TEX_MASK);
                center_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_depth_byte = depth_reg;
    assign m_angle_byte = angle_reg;
    assign m_texel      = texel_reg;
    assign m_at_center  = center_reg;

endmodule

/* src/tepg_checker.sv */
module tepg_checker import tepg_pkg::*; #(
    parameter int TEX_BITS = 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_depth_byte,
    input logic [OUT_W-1:0] m_angle_byte,
    input logic [OUT_W-1:0] m_texel,
    input logic             m_at_center
);

    localparam logic [OUT_W-1:0] TEX_MASK = OUT_W'(2 ** TEX_BITS - 1);

    // Hold the texel and center flag of a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_texel) && $stable(m_at_center))
        else $error("stalled result changed");

    // Accept input whenever the output stage is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // Center pixel clears all values
    a_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_at_center |-> m_depth_byte == '0 && m_angle_byte == '0 && m_texel == '0)
        else $error("center pixel not cleared");

    // Texel is the XOR of depth and angle
    a_texel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_texel == ((m_depth_byte ^ m_angle_byte) & TEX_MASK))
        else $error("texel mismatch");

endmodule

bind tunnel_effect_pixel_gen_unit tepg_checker #(.TEX_BITS(TEX_BITS)) u_tepg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_depth_byte (m_depth_byte),
    .m_angle_byte (m_angle_byte),
    .m_texel      (m_texel),
    .m_at_center  (m_at_center)
);
